// File: rtl/rgb_lamp_effect_engine_defines.svh
// Assertion macros shared by the lamp effect engine RTL.
// Stand-alone header; no dependencies.
`ifndef RGB_LAMP_EFFECT_ENGINE_DEFINES_SVH
`define RGB_LAMP_EFFECT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RLEE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rlee_pkg.sv
// Types and constants of the lamp effect engine.
// No dependencies; used by the channel interfaces, the core and the top level.
package rlee_pkg;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_FLASH   = 3'd1,
      OP_MONO    = 3'd2,
      OP_COLOUR  = 3'd3,
      OP_FADE_UP = 3'd4,
      OP_FADE_DN = 3'd5,
      OP_OFF     = 3'd6,
      OP_INIT    = 3'd7
   } op_type;

   localparam int COLOR_W = 3;
   localparam int DUTY_W  = 8;
   localparam int FLAGS_W = 5;

   // Colour code that leaves the enables as they are.
   localparam logic [COLOR_W-1:0] COLOR_KEEP = 3'd7;

   // Mode flag positions.
   localparam int FLAG_COLOURFUL = 0;
   localparam int FLAG_FLASH     = 1;
   localparam int FLAG_MONO      = 2;
   localparam int FLAG_DOWN      = 3;
   localparam int FLAG_UP        = 4;

   // Ramp breakpoints.
   localparam logic [DUTY_W-1:0] MONO_TOP    = 8'd160;
   localparam logic [DUTY_W-1:0] RAMP_TOP    = 8'd135;
   localparam logic [DUTY_W-1:0] RAMP_JUMP   = 8'd138;
   localparam logic [DUTY_W-1:0] LVL_5       = 8'd5;
   localparam logic [DUTY_W-1:0] LVL_15      = 8'd15;
   localparam logic [DUTY_W-1:0] LVL_20      = 8'd20;
   localparam logic [DUTY_W-1:0] LVL_25      = 8'd25;
   localparam logic [DUTY_W-1:0] LVL_30      = 8'd30;
   localparam logic [DUTY_W-1:0] LVL_35      = 8'd35;
   localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'd255;
   localparam logic [DUTY_W-1:0] BREATH_SLOW = 8'd5;
   localparam logic [COLOR_W-1:0] COLOUR_LAST = 3'd7;

   typedef struct packed {
      op_type              operation;
      logic [COLOR_W-1:0]  color;
      logic [7:0]          flash_period;
   } item_type;

   // rgb: bit 0 red, bit 1 green, bit 2 blue.
   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [2:0]        rgb;
   } lamp_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic [2:0]         rgb;
      logic [FLAGS_W-1:0] flags;
      logic               rising;
      logic [COLOR_W-1:0] colour_idx;
      logic [7:0]         breath_cnt;
      logic [7:0]         breath_lim;
      logic [7:0]         flash_cnt;
      logic [7:0]         flash_rld;
      logic               flash_lit;
      logic [7:0]         up_cnt;
      logic [7:0]         up_lim;
      logic [7:0]         down_cnt;
      logic [7:0]         down_lim;
   } state_type;

   localparam state_type STATE_RESET = '{
      duty: 8'd0, rgb: 3'd0, flags: 5'd0, rising: 1'b1, colour_idx: 3'd0,
      breath_cnt: 8'd0, breath_lim: 8'd5, flash_cnt: 8'd0, flash_rld: 8'd0,
      flash_lit: 1'b0, up_cnt: 8'd0, up_lim: 8'd1, down_cnt: 8'd0, down_lim: 8'd1
   };

   // Enables for colours 0 (red) through 6 (white).
   function automatic logic [2:0] colour_enables(input logic [COLOR_W-1:0] c);
      logic [2:0] e;
      case (c)
         3'd0:    e = 3'b001;
         3'd1:    e = 3'b011;
         3'd2:    e = 3'b010;
         3'd3:    e = 3'b110;
         3'd4:    e = 3'b100;
         3'd5:    e = 3'b101;
         3'd6:    e = 3'b111;
         default: e = 3'b000;
      endcase
      return e;
   endfunction

endpackage

// File: rtl/rlee_req_if.sv
// Request channel of the lamp effect engine: valid/ready plus one command beat.
// Depends on rlee_pkg.
interface rlee_req_if;
   import rlee_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic [COLOR_W-1:0]  color;
   logic [7:0]          flash_period;

   modport source (output valid, output operation, output color, output flash_period,
                   input ready);
   modport sink   (input valid, input operation, input color, input flash_period,
                   output ready);
endinterface

// File: rtl/rlee_rsp_if.sv
// Response channel of the lamp effect engine: valid/ready plus one lamp beat.
// Depends on rlee_pkg.
interface rlee_rsp_if;
   import rlee_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty;
   logic              red_on;
   logic              green_on;
   logic              blue_on;

   modport source (output valid, output duty, output red_on, output green_on,
                   output blue_on, input ready);
   modport sink   (input valid, input duty, input red_on, input green_on,
                   input blue_on, output ready);
endinterface

// File: rtl/rlee_core.sv
// Lamp state registers and the combinational update for one command or tick.
// Depends on rlee_pkg.
module rlee_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  rlee_pkg::item_type item,
   output rlee_pkg::lamp_type lamp
);
   import rlee_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_type s;
      logic [7:0] cnt;
      logic [DUTY_W-1:0] lvl;
      s = state_ff;
      cnt = 8'd0;
      lvl = 8'd0;
      case (item.operation)
         OP_TICK: begin
            if (s.flags[FLAG_COLOURFUL]) begin
               cnt = s.breath_cnt + 8'd1;
               if (cnt != s.breath_lim) begin
                  s.breath_cnt = cnt;
               end else begin
                  s.breath_cnt = 8'd0;
                  if (s.rising) begin
                     lvl = s.duty + 8'd1;
                     s.duty = lvl;
                     if (lvl == LVL_15)      s.breath_lim = 8'd4;
                     else if (lvl == LVL_20) s.breath_lim = 8'd3;
                     else if (lvl == LVL_25) s.breath_lim = 8'd2;
                     else if (lvl == LVL_35) s.breath_lim = 8'd1;
                     else if (lvl == RAMP_TOP) begin
                        s.duty = RAMP_JUMP;
                        s.rising = 1'b0;
                        s.breath_lim = 8'd1;
                     end
                  end else begin
                     lvl = s.duty - 8'd1;
                     s.duty = lvl;
                     if (lvl == LVL_25)      s.breath_lim = 8'd2;
                     else if (lvl == LVL_15) s.breath_lim = 8'd3;
                     else if (lvl == LVL_5) begin
                        // Bottom of the breath: step to the next colour, skipping code 7.
                        s.colour_idx = s.colour_idx + 3'd1;
                        if (s.colour_idx == COLOUR_LAST) s.colour_idx = 3'd0;
                        s.rgb = colour_enables(s.colour_idx);
                        s.rising = 1'b1;
                        s.breath_lim = BREATH_SLOW;
                     end
                  end
               end
            end else if (s.flags[FLAG_FLASH]) begin
               s.duty = s.flash_lit ? DUTY_FULL : 8'd0;
               cnt = s.flash_cnt - 8'd1;
               s.flash_cnt = cnt;
               if (cnt == 8'd0) begin
                  s.flash_cnt = s.flash_rld;
                  if (s.flash_lit) begin
                     if (s.flash_rld != 8'd0) s.flash_lit = 1'b0;
                  end else begin
                     s.flash_lit = 1'b1;
                  end
               end
            end else if (s.flags[FLAG_MONO]) begin
               if (s.rising) begin
                  lvl = s.duty + 8'd1;
                  s.duty = lvl;
                  if (lvl == MONO_TOP) s.rising = 1'b0;
               end else begin
                  lvl = s.duty - 8'd1;
                  s.duty = lvl;
                  if (lvl == 8'd0) s.rising = 1'b1;
               end
            end else if (s.flags[FLAG_DOWN]) begin
               cnt = s.down_cnt + 8'd1;
               if (cnt != s.down_lim) begin
                  s.down_cnt = cnt;
               end else begin
                  s.down_cnt = 8'd0;
                  lvl = s.duty - 8'd1;
                  s.duty = lvl;
                  if (lvl == LVL_30)      s.down_lim = 8'd2;
                  else if (lvl == LVL_25) s.down_lim = 8'd3;
                  else if (lvl == LVL_20) s.down_lim = 8'd4;
                  else if (lvl == LVL_15) s.down_lim = 8'd5;
                  else if (lvl == LVL_5)  s.down_lim = 8'd1;
                  if (lvl == 8'd0) begin
                     s.rgb = 3'd0;
                     s.flags[FLAG_DOWN] = 1'b0;
                  end
               end
            end else if (s.flags[FLAG_UP]) begin
               cnt = s.up_cnt + 8'd1;
               if (cnt != s.up_lim) begin
                  s.up_cnt = cnt;
               end else begin
                  s.up_cnt = 8'd0;
                  lvl = s.duty + 8'd1;
                  s.duty = lvl;
                  if (lvl == LVL_15)      s.up_lim = 8'd4;
                  else if (lvl == LVL_20) s.up_lim = 8'd3;
                  else if (lvl == LVL_25) s.up_lim = 8'd2;
                  else if (lvl == LVL_35) s.up_lim = 8'd1;
                  else if (lvl == RAMP_TOP) begin
                     s.up_lim = 8'd1;
                     s.flags[FLAG_UP] = 1'b0;
                  end
               end
            end
         end
         OP_FLASH: begin
            if (item.color != COLOR_KEEP) s.rgb = colour_enables(item.color);
            // A flash while already flashing keeps the running count and phase.
            if (!s.flags[FLAG_FLASH]) begin
               s.flash_lit = 1'b1;
               s.flash_cnt = item.flash_period;
            end
            s.flags = '0;
            s.flags[FLAG_FLASH] = 1'b1;
            s.flash_rld = item.flash_period;
         end
         OP_MONO: begin
            if (item.color != COLOR_KEEP) s.rgb = colour_enables(item.color);
            s.colour_idx = item.color;
            s.rising = 1'b1;
            s.duty = 8'd0;
            s.flags = '0;
            s.flags[FLAG_MONO] = 1'b1;
         end
         OP_COLOUR: begin
            if (item.color != COLOR_KEEP) s.rgb = colour_enables(item.color);
            s.colour_idx = item.color;
            s.breath_cnt = 8'd0;
            s.breath_lim = BREATH_SLOW;
            s.duty = 8'd0;
            s.rising = 1'b1;
            s.flags = '0;
            s.flags[FLAG_COLOURFUL] = 1'b1;
         end
         OP_FADE_UP: begin
            if (item.color != COLOR_KEEP) s.rgb = colour_enables(item.color);
            s.duty = 8'd0;
            s.up_lim = 8'd1;
            s.up_cnt = 8'd0;
            s.flags[FLAG_UP] = 1'b1;
         end
         OP_FADE_DN: begin
            s.down_lim = 8'd1;
            s.down_cnt = 8'd0;
            s.flags[FLAG_DOWN] = 1'b1;
         end
         OP_OFF: begin
            s.flags = '0;
            s.rgb = 3'd0;
         end
         OP_INIT: begin
            // Init keeps both fade flags.
            s.rgb = 3'd0;
            s.flash_cnt = 8'd0;
            s.flash_rld = 8'd0;
            s.flash_lit = 1'b0;
            s.colour_idx = 3'd0;
            s.breath_cnt = 8'd0;
            s.breath_lim = BREATH_SLOW;
            s.duty = 8'd0;
            s.rising = 1'b1;
            s.flags[FLAG_COLOURFUL] = 1'b0;
            s.flags[FLAG_FLASH] = 1'b0;
            s.flags[FLAG_MONO] = 1'b0;
         end
         default: begin
            s = state_ff;
         end
      endcase
      state_in = step ? s : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign lamp.duty = state_ff.duty;
   assign lamp.rgb  = state_ff.rgb;

endmodule

// File: rtl/rgb_lamp_effect_engine.sv
// Top level of the RGB lamp effect engine: request register, lamp core, response flag.
// Depends on rlee_pkg, rlee_req_if, rlee_rsp_if, rlee_core and the defines header.
//
// Usage. Each request beat on req_ch carries an operation (tick, flash, mono breath,
// colour breath, fade up, fade down, off, init), a colour code and a flash half-period.
// Every request beat produces exactly one response beat on rsp_ch with the PWM duty
// and the red, green and blue enables as they stand after that beat has taken effect.
// Beats are moved at rising clock edges where valid and ready are both high.
// A request is captured in the request register, and once the response slot is free or
// draining the lamp core updates its state registers, which drive the response.
// Throughput is one beat per cycle while the receiver does not stall; all the work for
// a beat is a handful of 8-bit increments and compares in the core.
// When the receiver stalls, the response stays put with the core state frozen, one
// more request is still taken into the request register, and only then req_ch.ready
// drops. It rises again in the cycle the pending response is taken.
// Synchronous reset clears both valid flags and puts the lamp into its reset state:
// duty zero, all enables off, no mode active, flash and fade counters cleared.
// No response is presented until the first request has been processed.
`include "rgb_lamp_effect_engine_defines.svh"

module rgb_lamp_effect_engine (
   input  logic     clock,
   input  logic     reset,
   rlee_req_if.sink   req_ch,
   rlee_rsp_if.source rsp_ch
);
   import rlee_pkg::*;

   // Request register: holds one accepted beat until the core takes it.
   logic     req_valid_ff;
   logic     req_valid_in;
   item_type req_item_ff;
   item_type req_item_in;

   // The response payload is the core state itself, so only a valid flag is kept here.
   logic     rsp_valid_ff;
   logic     rsp_valid_in;

   logic     advance;
   lamp_type lamp;

   // Both slots occupied and the receiver not taking the response.
   logic     full_stall;
   // An off command is being applied this cycle.
   logic     off_step;

   // The core processes the held request when the response slot is free or draining.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_ch.ready) begin
         req_valid_in = req_ch.valid;
         req_item_in  = '{operation: req_ch.operation, color: req_ch.color,
                          flash_period: req_ch.flash_period};
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
   end

   rlee_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (req_item_ff),
      .lamp  (lamp)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.duty     = lamp.duty;
   assign rsp_ch.red_on   = lamp.rgb[0];
   assign rsp_ch.green_on = lamp.rgb[1];
   assign rsp_ch.blue_on  = lamp.rgb[2];

   assign full_stall = req_valid_ff && rsp_valid_ff && !rsp_ch.ready;
   assign off_step   = advance && (req_item_ff.operation == OP_OFF);

   // The lamp state may only move when a request is processed.
   `RLEE_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(lamp), "lamp moved")
   // Every processed request leaves a response waiting.
   `RLEE_ASSERT_NEXT(a_rsp_follows, clock, reset, advance, rsp_valid_ff, "response lost")
   // A full request register behind a stalled response must block the input.
   `RLEE_ASSERT_NOW(a_back_pressure, clock, reset, full_stall, !req_ch.ready, "input open")
   // Off clears all enables.
   `RLEE_ASSERT_NEXT(a_off_dark, clock, reset, off_step, lamp.rgb == 3'd0, "off left a colour on")

endmodule
